// ===== rtl/plac_pkg.sv =====
// Shared types and constants for the polyline length accumulator.
package plac_pkg;

    localparam int INDEX_WIDTH   = 32;
    localparam int OUT_LEN_WIDTH = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== rtl/plac_sumsq.sv =====
// Difference magnitudes and sum of squares through one shared multiplier.
module plac_sumsq
    import plac_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [COORD_WIDTH-1:0]      cur_x,
    input  logic signed [COORD_WIDTH-1:0]      cur_y,
    input  logic signed [COORD_WIDTH-1:0]      cur_z,
    input  logic signed [COORD_WIDTH-1:0]      prev_x,
    input  logic signed [COORD_WIDTH-1:0]      prev_y,
    input  logic signed [COORD_WIDTH-1:0]      prev_z,
    output logic [2*(COORD_WIDTH+1)-1:0]       sum_sq,
    output unit_status_t                       status
);

    localparam int P     = COORD_WIDTH + 1;
    localparam int SUM_W = 2 * P;

    logic [P-1:0]     mag_reg [3];
    logic [1:0]       cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [SUM_W-1:0] prod_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [P-1:0]     sel;
    logic [SUM_W-1:0] prod_next;
    logic             last_step;

    function automatic logic [P-1:0] magnitude(input logic signed [COORD_WIDTH-1:0] a,
                                               input logic signed [COORD_WIDTH-1:0] b);
        logic signed [P-1:0] d;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        return d[P-1] ? P'(-d) : P'(d);
    endfunction

    assign sel       = (cnt_reg == 2'd3) ? mag_reg[0] : mag_reg[cnt_reg];
    assign prod_next = sel * sel;
    assign last_step = active_reg && (cnt_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            done_reg <= last_step;
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= 2'd0;
            end else if (active_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (last_step) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg[0] <= magnitude(cur_x, prev_x);
            mag_reg[1] <= magnitude(cur_y, prev_y);
            mag_reg[2] <= magnitude(cur_z, prev_z);
            sum_reg    <= '0;
        end else if (active_reg) begin
            prod_reg <= prod_next;
            if (cnt_reg != 2'd0) begin
                sum_reg <= sum_reg + prod_reg;
            end
        end
    end

    assign sum_sq      = sum_reg;
    assign status.busy = active_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/plac_isqrt.sv =====
// Iterative floor square root, one bit pair per cycle.
module plac_isqrt
    import plac_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [2*(COORD_WIDTH+1)-1:0]     radicand,
    output logic [COORD_WIDTH:0]             root,
    output unit_status_t                     status
);

    localparam int P     = COORD_WIDTH + 1;
    localparam int SUM_W = 2 * P;
    localparam int CNT_W = $clog2(P + 1);

    logic [SUM_W-1:0] rad_reg;
    logic [P+1:0]     rem_reg;
    logic [P-1:0]     q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [P+1:0]     rem_sh;
    logic [P+1:0]     trial;
    logic             fits;

    assign rem_sh = {rem_reg[P-1:0], rad_reg[SUM_W-1 -: 2]};
    assign trial  = {q_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= active_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(P);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg <= radicand;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (active_reg) begin
            rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
            if (fits) begin
                rem_reg <= rem_sh - trial;
                q_reg   <= {q_reg[P-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[P-2:0], 1'b0};
            end
        end
    end

    assign root        = q_reg;
    assign status.busy = active_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/polyline_length_accumulator_top.sv =====
// Top level: sequencer, track state and output register of the polyline length accumulator.
//
// Usage: points of a track arrive as beats on the s_ channel, x in the low
// COORD_WIDTH bits of s_tdata, then y, then z; s_tlast marks the last point of
// a track. Each beat that closes a track gives one beat on the m_ channel with
// the track index (m_tdata low 32 bits), the track length in coordinate units
// (m_tdata high 32 bits) and the saturation flag on m_tuser.
// The first point of a track skips the arithmetic and adds a zero segment.
// A later point takes four passes through the shared squaring multiplier,
// then COORD_WIDTH + 1 steps of the bit-serial square root, then the
// accumulate. s_tready is high only while idle.
// A finished result sits in the output register; the next point is accepted
// while it waits, and only the next track end holds until m_tready takes the
// pending beat. Reset (aresetn low, synchronous) clears the track state,
// the track counter and m_tvalid.
module polyline_length_accumulator_top
    import plac_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int LENGTH_WIDTH = 32,
    localparam int S_TDATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [S_TDATA_W-1:0]                 s_tdata,   // x_coord, y_coord, z_coord
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [INDEX_WIDTH+OUT_LEN_WIDTH-1:0] m_tdata,   // track_index, track_length
    output logic                                 m_tuser    // length_saturated
);

    localparam int CW    = COORD_WIDTH;
    localparam int P     = CW + 1;
    localparam int ACC_W = ((P > LENGTH_WIDTH) ? P : LENGTH_WIDTH) + 1;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
    localparam logic [LENGTH_WIDTH+OUT_LEN_WIDTH-1:0] LENGTH_MAX_EXT =
        {{OUT_LEN_WIDTH{1'b0}}, LENGTH_MAX};
    localparam logic [OUT_LEN_WIDTH-1:0] LENGTH_MAX_OUT = LENGTH_MAX_EXT[OUT_LEN_WIDTH-1:0];

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SUMSQ = 2'd1;
    localparam logic [1:0] S_ROOT  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic signed [CW-1:0]           cur_x_reg, cur_y_reg, cur_z_reg;
    logic                           cur_last_reg;
    logic signed [CW-1:0]           prev_x_reg, prev_y_reg, prev_z_reg;
    logic                           have_prev_reg;
    logic [LENGTH_WIDTH-1:0]        len_reg;
    logic                           ovf_reg;
    logic [INDEX_WIDTH-1:0]         tracks_reg;
    logic [P-1:0]                   seg_reg;
    logic                           m_tvalid_reg;
    logic [INDEX_WIDTH-1:0]         m_index_reg;
    logic [OUT_LEN_WIDTH-1:0]       m_length_reg;
    logic                           m_sat_reg;

    logic                           s_accept;
    logic                           sq_start;
    logic [2*P-1:0]                 sum_sq;
    logic [P-1:0]                   root;
    unit_status_t                   sq_st;
    unit_status_t                   rt_st;
    logic [ACC_W-1:0]               len_sum;
    logic                           len_sat;
    logic [LENGTH_WIDTH-1:0]        len_new;
    logic [LENGTH_WIDTH+OUT_LEN_WIDTH-1:0] len_ext;
    logic                           out_free;
    logic                           advance;
    logic                           out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign sq_start = s_accept && have_prev_reg;

    plac_sumsq #(.COORD_WIDTH(CW)) u_sumsq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .cur_x    (s_tdata[CW-1:0]),
        .cur_y    (s_tdata[2*CW-1:CW]),
        .cur_z    (s_tdata[3*CW-1:2*CW]),
        .prev_x   (prev_x_reg),
        .prev_y   (prev_y_reg),
        .prev_z   (prev_z_reg),
        .sum_sq   (sum_sq),
        .status   (sq_st)
    );

    plac_isqrt #(.COORD_WIDTH(CW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_st.done),
        .radicand (sum_sq),
        .root     (root),
        .status   (rt_st)
    );

    assign len_sum  = ACC_W'(len_reg) + ACC_W'(seg_reg);
    assign len_sat  = len_sum > ACC_W'(LENGTH_MAX);
    assign len_new  = len_sat ? LENGTH_MAX : len_sum[LENGTH_WIDTH-1:0];
    assign len_ext  = {{OUT_LEN_WIDTH{1'b0}}, len_new};
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = (state_reg == S_DONE) && (!cur_last_reg || out_free);
    assign out_load = advance && cur_last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = have_prev_reg ? S_SUMSQ : S_DONE;
                end
            end
            S_SUMSQ: begin
                if (sq_st.done) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (rt_st.done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (advance) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            have_prev_reg <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            tracks_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (advance) begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_z_reg <= cur_z_reg;
                if (cur_last_reg) begin
                    have_prev_reg <= 1'b0;
                    len_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    tracks_reg    <= tracks_reg + INDEX_WIDTH'(1);
                end else begin
                    have_prev_reg <= 1'b1;
                    len_reg       <= len_new;
                    ovf_reg       <= ovf_reg | len_sat;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_x_reg    <= s_tdata[CW-1:0];
            cur_y_reg    <= s_tdata[2*CW-1:CW];
            cur_z_reg    <= s_tdata[3*CW-1:2*CW];
            cur_last_reg <= s_tlast;
            seg_reg      <= '0;
        end else if (rt_st.done) begin
            seg_reg <= root;
        end
        if (out_load) begin
            m_index_reg  <= tracks_reg;
            m_length_reg <= len_ext[OUT_LEN_WIDTH-1:0];
            m_sat_reg    <= ovf_reg | len_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_length_reg, m_index_reg};
    assign m_tuser  = m_sat_reg;

    a_idle_units_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sq_st.busy && !rt_st.busy)
        else $error("input accepted while an arithmetic unit is busy");

    a_root_after_sumsq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(rt_st.busy) |-> $past(sq_st.done))
        else $error("square root started without a finished sum of squares");

    a_sat_holds_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[INDEX_WIDTH+OUT_LEN_WIDTH-1:INDEX_WIDTH] == LENGTH_MAX_OUT)
        else $error("saturated length is not the maximum");

    a_index_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> tracks_reg == $past(tracks_reg) + INDEX_WIDTH'(1))
        else $error("track counter did not advance on a result");

endmodule
